>>> sv/mfb_pkg.sv
// ----------------------------------------------------------------------------
// mfb_pkg
// Types and constants shared by the max-flow core and its storage.
// ----------------------------------------------------------------------------
`default_nettype none

package mfb_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_ARCS  = 512;
  localparam int CAP_BITS  = 16;

  localparam int NODE_W = 6;
  localparam int ARC_W  = 9;
  localparam int DEG_W  = 10;
  localparam int CAP_W  = 16;
  localparam int FLOW_W = 17;
  localparam int ROOM_W = 18;
  localparam int TOT_W  = 25;
  localparam int CNTN_W = 7;

  localparam logic [CAP_W-1:0] CAP_MASK = CAP_W'((32'd1 << CAP_BITS) - 32'd1);
  localparam logic [DEG_W-1:0] ARCS_FULL = DEG_W'(MAX_ARCS - 2);
  localparam logic [CNTN_W-1:0] NODES_LIM = CNTN_W'(MAX_NODES);
  localparam logic signed [ROOM_W-1:0] ROOM_MAX = {1'b0, {(ROOM_W-1){1'b1}}};

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD_A,
    S_ADD_R,
    S_ADD_B,
    S_RD_NODE,
    S_RD_WALK,
    S_RD_WALKW,
    S_RD_ARC,
    S_BFS_INIT,
    S_POP,
    S_POPW,
    S_NODEW,
    S_ARC,
    S_ARCW,
    S_BN_RD,
    S_BN_PW,
    S_BN_AW,
    S_AU_RD,
    S_AU_PW,
    S_AU_AW,
    S_AU_RW,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0]        target;
    logic [CAP_W-1:0]         cap;
    logic signed [FLOW_W-1:0] flow;
    logic [ARC_W-1:0]         partner;
  } arc_t;

  typedef struct packed {
    logic [ARC_W-1:0] head;
    logic [ARC_W-1:0] tail;
    logic [DEG_W-1:0] deg;
  } node_t;

  typedef struct packed {
    logic [NODE_W-1:0] pnode;
    logic [ARC_W-1:0]  parc;
  } parent_t;

endpackage

`default_nettype wire

>>> sv/mfb_ram.sv
// ----------------------------------------------------------------------------
// mfb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/max_flow_bfs_augment_core.sv
// ----------------------------------------------------------------------------
// max_flow_bfs_augment_core
// Edmonds-Karp max-flow engine over an arc store held in block RAM.
// ----------------------------------------------------------------------------
// Usage: one request beat on the in_ channel (valid/ready) gives exactly one
// result beat on the out_ channel (valid/ready). in_ready is high only while
// the sequencer is idle; one request is processed at a time.
// Read arc walks the next-arc list, one RAM read per link. Run: each search
// dequeues nodes and scans their arcs, then a bottleneck pass and an update
// pass walk the path arcs; arc reads go through the single read port of the
// arc store, capacity arithmetic through one shared 18-bit add/subtract unit.
// A finished result sits in the output register until out_ready takes it;
// a new request is taken while it waits, but the next result holds back
// until the output register is free.
// Synchronous reset (rst_n low) empties the network, sets node_count to 64
// and drops any pending result. No clearing pass is needed: per-node valid
// bits stand for the empty degree table. cfg_we writes node_count at once
// and must only be used while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module max_flow_bfs_augment_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [6:0]          cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_req_type,
  input  wire logic [5:0]          in_node_a,
  input  wire logic [5:0]          in_node_b,
  input  wire logic [15:0]         in_capacity,
  input  wire logic [8:0]          in_edge_slot,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_status,
  output logic [8:0]               out_slot_out,
  output logic [24:0]              out_total_flow,
  output logic [5:0]               out_arc_head,
  output logic [15:0]              out_arc_cap,
  output logic signed [16:0]       out_arc_flow
);

  localparam int NW = mfb_pkg::NODE_W;
  localparam int AW = mfb_pkg::ARC_W;
  localparam int DW = mfb_pkg::DEG_W;
  localparam int RW = mfb_pkg::ROOM_W;
  localparam int FW = mfb_pkg::FLOW_W;
  localparam int TW = mfb_pkg::TOT_W;
  localparam int CW = mfb_pkg::CNTN_W;

  mfb_pkg::state_t state_r, state_nxt;

  logic [NW-1:0] na_r, na_nxt, nb_r, nb_nxt, u_r, u_nxt, v_r, v_nxt;
  logic [mfb_pkg::CAP_W-1:0] cap_r, cap_nxt;
  logic [AW-1:0] slot_r, slot_nxt, a_r, a_nxt, pa_r, pa_nxt;
  logic [DW-1:0] k_r, k_nxt, deg_r, deg_nxt, arcs_used_r, arcs_used_nxt;
  logic [CW-1:0] q_head_r, q_head_nxt, q_tail_r, q_tail_nxt;
  logic [CW-1:0] node_count_r, node_count_nxt;
  logic [mfb_pkg::MAX_NODES-1:0] visited_r, visited_nxt, deg_vld_r, deg_vld_nxt;
  logic signed [RW-1:0] bn_r, bn_nxt;
  logic [TW-1:0] tot_r, tot_nxt;

  logic          res_status_r, res_status_nxt;
  logic [AW-1:0] res_slot_r, res_slot_nxt;
  logic [TW-1:0] res_total_r, res_total_nxt;
  logic [NW-1:0] res_head_r, res_head_nxt;
  logic [mfb_pkg::CAP_W-1:0] res_cap_r, res_cap_nxt;
  logic signed [FW-1:0] res_flow_r, res_flow_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_status_r, out_status_nxt;
  logic [AW-1:0] out_slot_r, out_slot_nxt;
  logic [TW-1:0] out_total_r, out_total_nxt;
  logic [NW-1:0] out_head_r, out_head_nxt;
  logic [mfb_pkg::CAP_W-1:0] out_cap_r, out_cap_nxt;
  logic signed [FW-1:0] out_flow_r, out_flow_nxt;

  // ram ports
  logic                  arc_we, nxt_we, node_we, par_we, q_we;
  logic [AW-1:0]         arc_waddr, arc_raddr, nxt_waddr, nxt_raddr, nxt_wdata;
  mfb_pkg::arc_t         arc_wdata, arc_rdata;
  logic [NW-1:0]         node_waddr, node_raddr, par_waddr, par_raddr;
  logic [NW-1:0]         q_waddr, q_raddr, q_wdata, q_rdata;
  mfb_pkg::node_t        node_wdata, node_rdata;
  mfb_pkg::parent_t      par_wdata, par_rdata;
  logic [AW-1:0]         nxt_rdata;

  mfb_ram #(.WIDTH($bits(mfb_pkg::arc_t)), .DEPTH(mfb_pkg::MAX_ARCS)) u_arc_ram (
    .clk, .we(arc_we), .waddr(arc_waddr), .wdata(arc_wdata),
    .raddr(arc_raddr), .rdata(arc_rdata)
  );

  mfb_ram #(.WIDTH(AW), .DEPTH(mfb_pkg::MAX_ARCS)) u_next_ram (
    .clk, .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(nxt_raddr), .rdata(nxt_rdata)
  );

  mfb_ram #(.WIDTH($bits(mfb_pkg::node_t)), .DEPTH(mfb_pkg::MAX_NODES)) u_node_ram (
    .clk, .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  mfb_ram #(.WIDTH($bits(mfb_pkg::parent_t)), .DEPTH(mfb_pkg::MAX_NODES)) u_par_ram (
    .clk, .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rdata)
  );

  mfb_ram #(.WIDTH(NW), .DEPTH(mfb_pkg::MAX_NODES)) u_queue_ram (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // shared add/subtract unit
  logic signed [RW-1:0] alu_a, alu_b, alu_y;
  logic                 alu_sub;
  assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  logic [CW-1:0] lim;
  assign lim = (node_count_r > mfb_pkg::NODES_LIM) ? mfb_pkg::NODES_LIM : node_count_r;

  logic [NW-1:0] deg_idx;
  logic [DW-1:0] deg_eff;
  assign deg_eff = deg_vld_r[deg_idx] ? node_rdata.deg : '0;

  logic [TW:0] tot_sum;
  assign tot_sum = {1'b0, tot_r} + (TW+1)'(bn_r[FW-1:0]);

  logic [AW-1:0] arc_f, arc_r;
  assign arc_f = arcs_used_r[AW-1:0];
  assign arc_r = arc_f + AW'(1);

  always_comb begin
    state_nxt      = state_r;
    na_nxt         = na_r;
    nb_nxt         = nb_r;
    cap_nxt        = cap_r;
    slot_nxt       = slot_r;
    u_nxt          = u_r;
    v_nxt          = v_r;
    a_nxt          = a_r;
    pa_nxt         = pa_r;
    k_nxt          = k_r;
    deg_nxt        = deg_r;
    arcs_used_nxt  = arcs_used_r;
    q_head_nxt     = q_head_r;
    q_tail_nxt     = q_tail_r;
    node_count_nxt = cfg_we ? cfg_wdata : node_count_r;
    visited_nxt    = visited_r;
    deg_vld_nxt    = deg_vld_r;
    bn_nxt         = bn_r;
    tot_nxt        = tot_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_total_nxt  = res_total_r;
    res_head_nxt   = res_head_r;
    res_cap_nxt    = res_cap_r;
    res_flow_nxt   = res_flow_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_total_nxt  = out_total_r;
    out_head_nxt   = out_head_r;
    out_cap_nxt    = out_cap_r;
    out_flow_nxt   = out_flow_r;

    arc_we     = 1'b0;
    arc_waddr  = pa_r;
    arc_wdata  = arc_rdata;
    arc_raddr  = a_r;
    nxt_we     = 1'b0;
    nxt_waddr  = node_rdata.tail;
    nxt_wdata  = arc_f;
    nxt_raddr  = a_r;
    node_we    = 1'b0;
    node_waddr = na_r;
    node_wdata = node_rdata;
    node_raddr = na_r;
    par_we     = 1'b0;
    par_waddr  = arc_rdata.target;
    par_wdata  = '{pnode: u_r, parc: a_r};
    par_raddr  = v_r;
    q_we       = 1'b0;
    q_waddr    = q_tail_r[NW-1:0];
    q_wdata    = arc_rdata.target;
    q_raddr    = q_head_r[NW-1:0];
    deg_idx    = na_r;
    alu_a      = RW'(arc_rdata.cap);
    alu_b      = RW'(arc_rdata.flow);
    alu_sub    = 1'b1;

    case (state_r)
      mfb_pkg::S_IDLE: begin
        if (in_valid) begin
          na_nxt         = in_node_a;
          nb_nxt         = in_node_b;
          cap_nxt        = in_capacity & mfb_pkg::CAP_MASK;
          slot_nxt       = in_edge_slot;
          res_status_nxt = 1'b0;
          res_slot_nxt   = '0;
          res_total_nxt  = '0;
          res_head_nxt   = '0;
          res_cap_nxt    = '0;
          res_flow_nxt   = '0;
          node_raddr     = in_node_a;
          case (mfb_pkg::req_t'(in_req_type))
            mfb_pkg::REQ_ADD: begin
              if ({1'b0, in_node_a} >= lim || {1'b0, in_node_b} >= lim ||
                  arcs_used_r > mfb_pkg::ARCS_FULL) begin
                res_status_nxt = 1'b1;
                state_nxt      = mfb_pkg::S_OUT;
              end else begin
                state_nxt = mfb_pkg::S_ADD_A;
              end
            end
            mfb_pkg::REQ_RUN: begin
              tot_nxt = '0;
              if ({1'b0, in_node_a} >= lim || {1'b0, in_node_b} >= lim) begin
                res_status_nxt = 1'b1;
                state_nxt      = mfb_pkg::S_OUT;
              end else if (in_node_a == in_node_b) begin
                state_nxt = mfb_pkg::S_OUT;
              end else begin
                state_nxt = mfb_pkg::S_BFS_INIT;
              end
            end
            mfb_pkg::REQ_READ: begin
              if ({1'b0, in_node_a} >= lim) begin
                res_status_nxt = 1'b1;
                state_nxt      = mfb_pkg::S_OUT;
              end else begin
                state_nxt = mfb_pkg::S_RD_NODE;
              end
            end
            default: begin
              deg_vld_nxt   = '0;
              arcs_used_nxt = '0;
              state_nxt     = mfb_pkg::S_OUT;
            end
          endcase
        end
      end

      // forward arc into node_a's list
      mfb_pkg::S_ADD_A: begin
        deg_idx   = na_r;
        arc_we    = 1'b1;
        arc_waddr = arc_f;
        arc_wdata = '{target: nb_r, cap: cap_r, flow: '0, partner: arc_r};
        nxt_we    = (deg_eff != '0);
        nxt_waddr = node_rdata.tail;
        nxt_wdata = arc_f;
        node_we   = 1'b1;
        node_waddr = na_r;
        node_wdata = '{head: (deg_eff == '0) ? arc_f : node_rdata.head,
                       tail: arc_f, deg: deg_eff + DW'(1)};
        deg_vld_nxt[na_r] = 1'b1;
        res_slot_nxt = deg_eff[AW-1:0];
        state_nxt    = mfb_pkg::S_ADD_R;
      end

      mfb_pkg::S_ADD_R: begin
        arc_we     = 1'b1;
        arc_waddr  = arc_r;
        arc_wdata  = '{target: na_r, cap: '0, flow: '0, partner: arc_f};
        node_raddr = nb_r;
        state_nxt  = mfb_pkg::S_ADD_B;
      end

      // reverse arc into node_b's list
      mfb_pkg::S_ADD_B: begin
        deg_idx    = nb_r;
        nxt_we     = (deg_eff != '0);
        nxt_waddr  = node_rdata.tail;
        nxt_wdata  = arc_r;
        node_we    = 1'b1;
        node_waddr = nb_r;
        node_wdata = '{head: (deg_eff == '0) ? arc_r : node_rdata.head,
                       tail: arc_r, deg: deg_eff + DW'(1)};
        deg_vld_nxt[nb_r] = 1'b1;
        arcs_used_nxt = arcs_used_r + DW'(2);
        state_nxt     = mfb_pkg::S_OUT;
      end

      mfb_pkg::S_RD_NODE: begin
        deg_idx = na_r;
        a_nxt   = node_rdata.head;
        k_nxt   = '0;
        if ({1'b0, slot_r} >= deg_eff) begin
          res_status_nxt = 1'b1;
          state_nxt      = mfb_pkg::S_OUT;
        end else begin
          state_nxt = mfb_pkg::S_RD_WALK;
        end
      end

      mfb_pkg::S_RD_WALK: begin
        arc_raddr = a_r;
        nxt_raddr = a_r;
        if (k_r == {1'b0, slot_r}) begin
          state_nxt = mfb_pkg::S_RD_ARC;
        end else begin
          state_nxt = mfb_pkg::S_RD_WALKW;
        end
      end

      mfb_pkg::S_RD_WALKW: begin
        a_nxt     = nxt_rdata;
        k_nxt     = k_r + DW'(1);
        state_nxt = mfb_pkg::S_RD_WALK;
      end

      mfb_pkg::S_RD_ARC: begin
        res_head_nxt = arc_rdata.target;
        res_cap_nxt  = arc_rdata.cap;
        res_flow_nxt = arc_rdata.flow;
        state_nxt    = mfb_pkg::S_OUT;
      end

      mfb_pkg::S_BFS_INIT: begin
        visited_nxt       = '0;
        visited_nxt[na_r] = 1'b1;
        q_we              = 1'b1;
        q_waddr           = '0;
        q_wdata           = na_r;
        q_head_nxt        = '0;
        q_tail_nxt        = CW'(1);
        state_nxt         = mfb_pkg::S_POP;
      end

      mfb_pkg::S_POP: begin
        q_raddr = q_head_r[NW-1:0];
        if (q_head_r == q_tail_r) begin
          res_total_nxt = tot_r;
          state_nxt     = mfb_pkg::S_OUT;
        end else begin
          q_head_nxt = q_head_r + CW'(1);
          state_nxt  = mfb_pkg::S_POPW;
        end
      end

      mfb_pkg::S_POPW: begin
        u_nxt      = q_rdata;
        node_raddr = q_rdata;
        state_nxt  = mfb_pkg::S_NODEW;
      end

      mfb_pkg::S_NODEW: begin
        deg_idx = u_r;
        a_nxt   = node_rdata.head;
        deg_nxt = deg_eff;
        k_nxt   = '0;
        state_nxt = (deg_eff == '0) ? mfb_pkg::S_POP : mfb_pkg::S_ARC;
      end

      mfb_pkg::S_ARC: begin
        arc_raddr = a_r;
        nxt_raddr = a_r;
        state_nxt = mfb_pkg::S_ARCW;
      end

      // spare capacity when cap - flow is above zero
      mfb_pkg::S_ARCW: begin
        a_nxt = nxt_rdata;
        k_nxt = k_r + DW'(1);
        state_nxt = (k_r + DW'(1) == deg_r) ? mfb_pkg::S_POP : mfb_pkg::S_ARC;
        if (!visited_r[arc_rdata.target] && alu_y > 0) begin
          visited_nxt[arc_rdata.target] = 1'b1;
          par_we = 1'b1;
          if (arc_rdata.target == nb_r) begin
            v_nxt     = nb_r;
            bn_nxt    = mfb_pkg::ROOM_MAX;
            state_nxt = mfb_pkg::S_BN_RD;
          end else if (q_tail_r < mfb_pkg::NODES_LIM) begin
            q_we       = 1'b1;
            q_tail_nxt = q_tail_r + CW'(1);
          end
        end
      end

      mfb_pkg::S_BN_RD: begin
        par_raddr = v_r;
        if (v_r == na_r) begin
          v_nxt     = nb_r;
          state_nxt = mfb_pkg::S_AU_RD;
        end else begin
          state_nxt = mfb_pkg::S_BN_PW;
        end
      end

      mfb_pkg::S_BN_PW: begin
        arc_raddr = par_rdata.parc;
        v_nxt     = par_rdata.pnode;
        state_nxt = mfb_pkg::S_BN_AW;
      end

      mfb_pkg::S_BN_AW: begin
        if (alu_y < bn_r) begin
          bn_nxt = alu_y;
        end
        state_nxt = mfb_pkg::S_BN_RD;
      end

      mfb_pkg::S_AU_RD: begin
        par_raddr = v_r;
        if (v_r == na_r) begin
          tot_nxt   = tot_sum[TW] ? '1 : tot_sum[TW-1:0];
          state_nxt = mfb_pkg::S_BFS_INIT;
        end else begin
          state_nxt = mfb_pkg::S_AU_PW;
        end
      end

      mfb_pkg::S_AU_PW: begin
        arc_raddr = par_rdata.parc;
        pa_nxt    = par_rdata.parc;
        v_nxt     = par_rdata.pnode;
        state_nxt = mfb_pkg::S_AU_AW;
      end

      mfb_pkg::S_AU_AW: begin
        alu_a          = RW'(arc_rdata.flow);
        alu_b          = bn_r;
        alu_sub        = 1'b0;
        arc_we         = 1'b1;
        arc_waddr      = pa_r;
        arc_wdata      = arc_rdata;
        arc_wdata.flow = alu_y[FW-1:0];
        arc_raddr      = arc_rdata.partner;
        pa_nxt         = arc_rdata.partner;
        state_nxt      = mfb_pkg::S_AU_RW;
      end

      mfb_pkg::S_AU_RW: begin
        alu_a          = RW'(arc_rdata.flow);
        alu_b          = bn_r;
        alu_sub        = 1'b1;
        arc_we         = 1'b1;
        arc_waddr      = pa_r;
        arc_wdata      = arc_rdata;
        arc_wdata.flow = alu_y[FW-1:0];
        state_nxt      = mfb_pkg::S_AU_RD;
      end

      mfb_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_total_nxt  = res_total_r;
          out_head_nxt   = res_head_r;
          out_cap_nxt    = res_cap_r;
          out_flow_nxt   = res_flow_r;
          state_nxt      = mfb_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = mfb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mfb_pkg::S_IDLE;
      arcs_used_r  <= '0;
      deg_vld_r    <= '0;
      node_count_r <= CW'(64);
      out_valid_r  <= 1'b0;
      q_head_r     <= '0;
      q_tail_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      arcs_used_r  <= arcs_used_nxt;
      deg_vld_r    <= deg_vld_nxt;
      node_count_r <= node_count_nxt;
      out_valid_r  <= out_valid_nxt;
      q_head_r     <= q_head_nxt;
      q_tail_r     <= q_tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    na_r         <= na_nxt;
    nb_r         <= nb_nxt;
    cap_r        <= cap_nxt;
    slot_r       <= slot_nxt;
    u_r          <= u_nxt;
    v_r          <= v_nxt;
    a_r          <= a_nxt;
    pa_r         <= pa_nxt;
    k_r          <= k_nxt;
    deg_r        <= deg_nxt;
    visited_r    <= visited_nxt;
    bn_r         <= bn_nxt;
    tot_r        <= tot_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_total_r  <= res_total_nxt;
    res_head_r   <= res_head_nxt;
    res_cap_r    <= res_cap_nxt;
    res_flow_r   <= res_flow_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_total_r  <= out_total_nxt;
    out_head_r   <= out_head_nxt;
    out_cap_r    <= out_cap_nxt;
    out_flow_r   <= out_flow_nxt;
  end

  assign in_ready       = (state_r == mfb_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_out   = out_slot_r;
  assign out_total_flow = out_total_r;
  assign out_arc_head   = out_head_r;
  assign out_arc_cap    = out_cap_r;
  assign out_arc_flow   = out_flow_r;

`ifndef SYNTH
  a_arcs_even: assert property (@(posedge clk) disable iff (!rst_n)
    !arcs_used_r[0] && arcs_used_r <= DW'(mfb_pkg::MAX_ARCS))
    else $error("arc count odd or beyond store");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != mfb_pkg::S_IDLE))
    else $error("sequencer idle after a request beat");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_head_r <= q_tail_r && q_tail_r <= mfb_pkg::NODES_LIM)
    else $error("search queue pointers out of order");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |->
      (out_slot_out == '0 && out_total_flow == '0 && out_arc_cap == '0))
    else $error("rejected result carries data");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfb_pkg::S_OUT && state_nxt == mfb_pkg::S_IDLE) |=> out_valid_r)
    else $error("result beat lost");
`endif

endmodule

`default_nettype wire

>>> dv/max_flow_bfs_augment_core_tb.sv
// ----------------------------------------------------------------------------
// max_flow_bfs_augment_core_tb
// Self-checking bench for the Edmonds-Karp flow core: a behavioral network
// model predicts every result beat, which is compared field by field with the
// DUT output under random bursts, gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module max_flow_bfs_augment_core_tb;

  localparam int LIMIT_CYCLES = 20000000;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    logic        status;
    logic [8:0]  slot;
    logic [24:0] total;
    logic [5:0]  head;
    logic [15:0] cap;
    logic [16:0] flow;
  } flow_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = '0;
  logic [5:0]  in_node_a = '0;
  logic [5:0]  in_node_b = '0;
  logic [15:0] in_capacity = '0;
  logic [8:0]  in_edge_slot = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status;
  logic [8:0]  out_slot_out;
  logic [24:0] out_total_flow;
  logic [5:0]  out_arc_head;
  logic [15:0] out_arc_cap;
  logic signed [16:0] out_arc_flow;

  max_flow_bfs_augment_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_node_a(in_node_a), .in_node_b(in_node_b),
    .in_capacity(in_capacity), .in_edge_slot(in_edge_slot),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_slot_out(out_slot_out),
    .out_total_flow(out_total_flow), .out_arc_head(out_arc_head),
    .out_arc_cap(out_arc_cap), .out_arc_flow(out_arc_flow)
  );

  always #5 clk = ~clk;

  // network copy kept by the bench
  logic [5:0] net_target [mfb_pkg::MAX_ARCS];
  int         net_cap    [mfb_pkg::MAX_ARCS];
  int         net_flow   [mfb_pkg::MAX_ARCS];
  int         net_mate   [mfb_pkg::MAX_ARCS];
  int         net_next   [mfb_pkg::MAX_ARCS];
  int         node_first [mfb_pkg::MAX_NODES];
  int         node_last  [mfb_pkg::MAX_NODES];
  int         node_deg   [mfb_pkg::MAX_NODES];
  int         arcs_taken;
  int         node_limit_reg;
  int         bfs_from_node [mfb_pkg::MAX_NODES];
  int         bfs_from_arc  [mfb_pkg::MAX_NODES];

  flow_result_t pending_results[$];
  int errors, beats_sent, beats_checked, cycles;
  int n_add, n_run, n_read, n_clear, n_reject;
  int burst_left, gap_mode, stall_mode, stall_phase;
  int hold_req, hold_seen, hold_left;

  function automatic bit find_path(int src, int snk);
    bit seen [mfb_pkg::MAX_NODES];
    int order [mfb_pkg::MAX_NODES];
    int qh, qt, u, a, k, to;
    for (int i = 0; i < mfb_pkg::MAX_NODES; i++) seen[i] = 1'b0;
    seen[src] = 1'b1;
    order[0] = src;
    qh = 0;
    qt = 1;
    while (qh < qt) begin
      u = order[qh];
      qh++;
      a = node_first[u];
      for (k = 0; k < node_deg[u]; k++) begin
        to = net_target[a];
        if (!seen[to] && net_cap[a] > net_flow[a]) begin
          seen[to] = 1'b1;
          bfs_from_node[to] = u;
          bfs_from_arc[to] = a;
          if (to == snk) return 1'b1;
          if (qt < mfb_pkg::MAX_NODES) begin
            order[qt] = to;
            qt++;
          end
        end
        a = net_next[a];
      end
    end
    return 1'b0;
  endfunction

  function automatic longint max_flow(int src, int snk);
    longint total;
    int neck, v, a, steps;
    total = 0;
    while (find_path(src, snk)) begin
      neck = 32'h7fffffff;
      v = snk;
      for (steps = 0; v != src && steps < mfb_pkg::MAX_NODES; steps++) begin
        a = bfs_from_arc[v];
        if (net_cap[a] - net_flow[a] < neck) neck = net_cap[a] - net_flow[a];
        v = bfs_from_node[v];
      end
      v = snk;
      for (steps = 0; v != src && steps < mfb_pkg::MAX_NODES; steps++) begin
        a = bfs_from_arc[v];
        net_flow[a] += neck;
        net_flow[net_mate[a]] -= neck;
        v = bfs_from_node[v];
      end
      total += neck;
    end
    return total;
  endfunction

  function automatic void link_arc(int nd, int a);
    if (node_deg[nd] == 0) node_first[nd] = a;
    else net_next[node_last[nd]] = a;
    node_last[nd] = a;
    node_deg[nd]++;
  endfunction

  function automatic flow_result_t predict_request(mfb_pkg::req_t rq, int na, int nb,
                                                   int cp, int sl);
    flow_result_t r;
    int lim, f, a;
    longint tot;
    r = '{default: '0};
    lim = (node_limit_reg > mfb_pkg::MAX_NODES) ? mfb_pkg::MAX_NODES : node_limit_reg;
    case (rq)
      mfb_pkg::REQ_ADD: begin
        if (na >= lim || nb >= lim || arcs_taken + 2 > mfb_pkg::MAX_ARCS) begin
          r.status = 1'b1;
        end else begin
          f = arcs_taken;
          arcs_taken += 2;
          net_target[f] = nb;     net_cap[f] = cp;     net_flow[f] = 0;
          net_mate[f] = f + 1;
          net_target[f+1] = na;   net_cap[f+1] = 0;    net_flow[f+1] = 0;
          net_mate[f+1] = f;
          link_arc(na, f);
          r.slot = 9'(node_deg[na] - 1);
          link_arc(nb, f + 1);
        end
      end
      mfb_pkg::REQ_RUN: begin
        if (na >= lim || nb >= lim) begin
          r.status = 1'b1;
        end else begin
          tot = (na == nb) ? 0 : max_flow(na, nb);
          r.total = (tot > 33554431) ? 25'h1ffffff : 25'(tot);
        end
      end
      mfb_pkg::REQ_READ: begin
        if (na >= lim || sl >= node_deg[na]) begin
          r.status = 1'b1;
        end else begin
          a = node_first[na];
          for (int s = 0; s < sl; s++) a = net_next[a];
          r.head = net_target[a];
          r.cap = 16'(net_cap[a]);
          r.flow = 17'(net_flow[a]);
        end
      end
      default: begin
        for (int i = 0; i < mfb_pkg::MAX_NODES; i++) node_deg[i] = 0;
        arcs_taken = 0;
      end
    endcase
    return r;
  endfunction

  // one request beat; valid stays up across a burst
  task automatic send_req(mfb_pkg::req_t rq, int na, int nb, int cp, int sl);
    flow_result_t r;
    in_valid <= 1'b1;
    in_req_type <= rq;
    in_node_a <= 6'(na);
    in_node_b <= 6'(nb);
    in_capacity <= 16'(cp);
    in_edge_slot <= 9'(sl);
    do @(posedge clk); while (!in_ready);
    r = predict_request(rq, na & 63, nb & 63, cp & 16'hffff, sl & 511);
    pending_results.insert(pending_results.size(), r);
    beats_sent++;
    if (r.status) n_reject++;
    case (rq)
      mfb_pkg::REQ_ADD: n_add++;
      mfb_pkg::REQ_RUN: n_run++;
      mfb_pkg::REQ_READ: n_read++;
      default: n_clear++;
    endcase
    if (gap_mode != 0) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 12);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_node_count(int v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= 7'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    node_limit_reg = v & 127;
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    flow_result_t e;
    if (rst_n && out_valid && out_ready) begin
      beats_checked++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none actual status %0d",
                 $time, out_status);
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, out_status);
        check_field("slot_out", e.slot, out_slot_out);
        check_field("total_flow", e.total, out_total_flow);
        check_field("arc_head", e.head, out_arc_head);
        check_field("arc_cap", e.cap, out_arc_cap);
        check_field("arc_flow", $signed(e.flow), out_arc_flow);
      end
    end
  end

  // receiver stall pattern and long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (stall_phase % 7) > 2;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_directed_ops();
    gap_mode = 0;
    stall_mode = 0;
    send_req(mfb_pkg::REQ_ADD, 0, 1, 16'hffff, 0);
    send_req(mfb_pkg::REQ_ADD, 1, 63, 16'h0000, 0);
    send_req(mfb_pkg::REQ_ADD, 1, 63, 16'h8001, 0);
    send_req(mfb_pkg::REQ_ADD, 5, 5, 16'h7ffe, 0);      // self loop
    send_req(mfb_pkg::REQ_ADD, 0, 63, 16'h00ff, 0);
    send_req(mfb_pkg::REQ_ADD, 63, 0, 16'h1234, 0);
    send_req(mfb_pkg::REQ_READ, 5, 0, 0, 0);
    send_req(mfb_pkg::REQ_READ, 5, 0, 0, 1);
    send_req(mfb_pkg::REQ_RUN, 0, 63, 0, 0);
    send_req(mfb_pkg::REQ_RUN, 7, 7, 0, 0);             // source is sink
    send_req(mfb_pkg::REQ_RUN, 0, 63, 0, 0);            // nothing left to push
    send_req(mfb_pkg::REQ_READ, 0, 0, 0, 0);
    send_req(mfb_pkg::REQ_READ, 1, 0, 0, 0);            // reverse arc, negative flow
    send_req(mfb_pkg::REQ_READ, 63, 0, 0, 2);
    send_req(mfb_pkg::REQ_READ, 0, 0, 0, 3);            // slot past degree
    send_req(mfb_pkg::REQ_READ, 0, 0, 0, 511);
    send_req(mfb_pkg::REQ_READ, 9, 0, 0, 0);            // empty node
    send_req(mfb_pkg::REQ_CLEAR, 0, 0, 0, 0);
    send_req(mfb_pkg::REQ_READ, 0, 0, 0, 0);
    send_req(mfb_pkg::REQ_RUN, 0, 63, 0, 0);
    drain_results();
  endtask

  task automatic test_node_count_limits();
    write_node_count(2);
    send_req(mfb_pkg::REQ_ADD, 0, 1, 100, 0);
    send_req(mfb_pkg::REQ_ADD, 0, 2, 100, 0);
    send_req(mfb_pkg::REQ_ADD, 2, 1, 100, 0);
    send_req(mfb_pkg::REQ_RUN, 1, 3, 0, 0);
    send_req(mfb_pkg::REQ_READ, 2, 0, 0, 0);
    write_node_count(127);                     // above the node array size
    send_req(mfb_pkg::REQ_ADD, 1, 63, 40, 0);
    send_req(mfb_pkg::REQ_ADD, 63, 1, 30, 0);
    write_node_count(2);                       // node 63 falls out of range again
    send_req(mfb_pkg::REQ_RUN, 0, 1, 0, 0);
    send_req(mfb_pkg::REQ_RUN, 63, 1, 0, 0);
    write_node_count(64);
    send_req(mfb_pkg::REQ_READ, 63, 0, 0, 0);
    send_req(mfb_pkg::REQ_CLEAR, 0, 0, 0, 0);
    drain_results();
  endtask

  task automatic test_store_full_and_backpressure();
    gap_mode = 0;
    stall_mode = 1;
    hold_req++;
    for (int i = 0; i < mfb_pkg::MAX_ARCS / 2; i++)
      send_req(mfb_pkg::REQ_ADD, (i % 4 == 3) ? $urandom_range(0, 63) : 0,
               $urandom_range(0, 63), $urandom_range(0, 16'hffff), 0);
    send_req(mfb_pkg::REQ_ADD, 1, 2, 5, 0);             // store full
    send_req(mfb_pkg::REQ_ADD, 63, 63, 5, 0);
    drain_results();                           // sender waits for every result
    for (int i = 0; i < 12; i++)
      send_req(mfb_pkg::REQ_READ, 0, 0, 0, $urandom_range(0, 511));
    send_req(mfb_pkg::REQ_READ, 0, 0, 0, 9'h0ff);
    send_req(mfb_pkg::REQ_RUN, 0, 63, 0, 0);
    send_req(mfb_pkg::REQ_RUN, 0, 1, 0, 0);
    send_req(mfb_pkg::REQ_CLEAR, 0, 0, 0, 0);
    drain_results();
  endtask

  task automatic test_random_networks();
    int nc, span, n_edges, cp, pick, a_node, b_node;
    while (beats_sent < 1750) begin
      pick = $urandom_range(0, 9);
      nc = (pick == 0) ? 64 : (pick == 1) ? 2 : (pick == 2) ? 127 : $urandom_range(3, 12);
      write_node_count(nc);
      span = (nc > 64) ? 64 : nc;
      gap_mode = $urandom_range(0, 2);
      stall_mode = $urandom_range(0, 2);
      send_req(mfb_pkg::REQ_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), 0, 0);
      n_edges = $urandom_range(1, (span > 8) ? 40 : 16);
      for (int i = 0; i < n_edges; i++) begin
        cp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hffff)
                                         : $urandom_range(0, 20);
        a_node = $urandom_range(0, span - 1);
        b_node = $urandom_range(0, span - 1);
        if ($urandom_range(0, 9) == 0) a_node = $urandom_range(0, 63);
        send_req(mfb_pkg::REQ_ADD, a_node, b_node, cp, 0);
      end
      for (int i = 0; i < 10; i++) begin
        pick = $urandom_range(0, 9);
        a_node = $urandom_range(0, span - 1);
        b_node = $urandom_range(0, span - 1);
        if (pick == 0)
          send_req(mfb_pkg::req_t'($urandom_range(0, 2)), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom, $urandom_range(0, 511));
        else if (pick < 4)
          send_req(mfb_pkg::REQ_RUN, a_node, b_node, 0, 0);
        else
          send_req(mfb_pkg::REQ_READ, a_node, 0, 0,
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                               : $urandom_range(0, 5));
      end
      drain_results();
    end
  endtask

  initial begin
    node_limit_reg = 64;
    arcs_taken = 0;
    for (int i = 0; i < mfb_pkg::MAX_NODES; i++) node_deg[i] = 0;
    errors = 0; beats_sent = 0; beats_checked = 0; cycles = 0;
    n_add = 0; n_run = 0; n_read = 0; n_clear = 0; n_reject = 0;
    burst_left = 0; gap_mode = 0; stall_mode = 0; stall_phase = 0;
    hold_req = 0; hold_seen = 0; hold_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_node_count_limits();
    test_store_full_and_backpressure();
    test_random_networks();
    drain_results();
    repeat (50) @(posedge clk);
    $display("run covered %0d beats (%0d adds, %0d runs, %0d reads, %0d clears, %0d rejected)",
             beats_sent, n_add, n_run, n_read, n_clear, n_reject);
    $display("%0d result beats checked, %0d mismatches", beats_checked, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
